FILE: hdl/tac_pkg.sv
// Shared types, constants and digit helpers for the temperature alarm controller.
package tac_pkg;

	typedef enum logic [2:0] {
		OP_BYTE    = 3'd0,
		OP_RAISE   = 3'd1,
		OP_LOWER   = 3'd2,
		OP_MODE    = 3'd3,
		OP_BUZZ    = 3'd4,
		OP_DISPLAY = 3'd5
	} op_t;

	localparam logic [7:0] MARKER_BYTE = 8'hca;
	localparam logic [7:0] SEG_H       = 8'h76;
	localparam logic [7:0] SEG_L       = 8'h38;
	localparam logic [7:0] SEG_BLANK   = 8'h00;
	localparam logic [7:0] TEMP_MAX_EX = 8'd100;

	localparam logic [7:0] RST_PREV_BYTE = 8'd11;
	localparam logic [6:0] RST_TEMP      = 7'd20;
	localparam logic [7:0] RST_UPPER     = 8'd30;
	localparam logic [7:0] RST_LOWER     = 8'd10;
	localparam logic       RST_UPPER_SEL = 1'b1;
	localparam logic       RST_ARMED     = 1'b1;
	localparam logic       RST_BUZZER    = 1'b1;
	localparam logic [2:0] RST_DIGIT     = 3'd1;

	localparam logic [2:0] POS_TEMP_TENS  = 3'd1;
	localparam logic [2:0] POS_TEMP_UNITS = 3'd2;
	localparam logic [2:0] POS_MODE_CHAR  = 3'd4;
	localparam logic [2:0] POS_LIM_HUND   = 3'd5;
	localparam logic [2:0] POS_LIM_TENS   = 3'd6;
	localparam logic [2:0] POS_LIM_UNITS  = 3'd7;

	typedef struct packed {
		logic [6:0] temperature;
		logic [7:0] shown_limit;
		logic       high_selected;
		logic       alarm_active;
		logic       buzzer_level;
		logic [2:0] digit_select;
		logic       led_flash;
	} res_t;

	// Seven-segment pattern of one decimal digit.
	function automatic logic [7:0] seg_digit(input logic [3:0] d);
		logic [7:0] s;
		case (d)
			4'd0:    s = 8'h3f;
			4'd1:    s = 8'h06;
			4'd2:    s = 8'h5b;
			4'd3:    s = 8'h4f;
			4'd4:    s = 8'h66;
			4'd5:    s = 8'h6d;
			4'd6:    s = 8'h7d;
			4'd7:    s = 8'h07;
			4'd8:    s = 8'h7f;
			4'd9:    s = 8'h6f;
			default: s = 8'h3f;
		endcase
		return s;
	endfunction

	// Tens digit of a value below 100, by multiplying with the reciprocal of ten.
	function automatic logic [3:0] tens_of(input logic [6:0] x);
		logic [14:0] p;
		p = {8'd0, x} * 15'd205;
		return p[14:11];
	endfunction

	// Units digit of a value below 100.
	function automatic logic [3:0] units_of(input logic [6:0] x);
		logic [6:0] t10;
		logic [6:0] r;
		t10 = {3'd0, tens_of(x)} * 7'd10;
		r   = x - t10;
		return r[3:0];
	endfunction

endpackage

FILE: hdl/temperature_alarm_controller.sv
// Temperature alarm controller: input register, event update, result register.
// An event is held in the input register, then in the result register, which drives out_valid.
// One event per cycle unless the result stalls; controller state updates with each event.
// A stalled result holds the result register; the input register keeps one more event.
// Reset clears both valid flags and loads the controller state with its reset values.
module temperature_alarm_controller (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] opcode,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [6:0] temperature,
	output logic [7:0] shown_limit,
	output logic       high_selected,
	output logic       alarm_active,
	output logic       buzzer_level,
	output logic [2:0] digit_select,
	output logic [7:0] segment_code,
	output logic       led_flash
);
	import tac_pkg::*;

	logic       valid_s1;
	op_t        op_s1;
	logic [7:0] rx_s1;
	logic       valid_s2;
	res_t       res_s2;
	res_t       nxt;
	logic       res_free;
	logic       adv;

	assign res_free = !valid_s2 || !out_stall;
	assign adv      = valid_s1 && res_free;
	assign in_stall = valid_s1 && !res_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1 <= op_t'(opcode);
			rx_s1 <= rx_byte;
		end
	end

	tac_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (adv),
		.op      (op_s1),
		.rx_byte (rx_s1),
		.nxt     (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (res_free) begin
			valid_s2 <= adv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= nxt;
		end
	end

	assign out_valid     = valid_s2;
	assign temperature   = res_s2.temperature;
	assign shown_limit   = res_s2.shown_limit;
	assign high_selected = res_s2.high_selected;
	assign alarm_active  = res_s2.alarm_active;
	assign buzzer_level  = res_s2.buzzer_level;
	assign digit_select  = res_s2.digit_select;
	assign led_flash     = res_s2.led_flash;

	tac_seg_decode u_seg (
		.temperature   (res_s2.temperature),
		.shown_limit   (res_s2.shown_limit),
		.high_selected (res_s2.high_selected),
		.digit_select  (res_s2.digit_select),
		.segment_code  (segment_code)
	);

	// An event that leaves the input register always lands in the result register.
	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s2)
		else $error("event left the input register without a result");

	// A flash is only raised while the alarm is active.
	a_flash_alarm: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.led_flash) |-> res_s2.alarm_active)
		else $error("led flash without an active alarm");

	// A stored temperature never reaches 100.
	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (res_s2.temperature < 7'd100))
		else $error("temperature out of range");

endmodule

FILE: hdl/tac_seg_decode.sv
// Seven-segment pattern for the digit position held in the result register.
module tac_seg_decode (
	input  logic [6:0] temperature,
	input  logic [7:0] shown_limit,
	input  logic       high_selected,
	input  logic [2:0] digit_select,
	output logic [7:0] segment_code
);
	import tac_pkg::*;

	logic [1:0] hund;
	logic [7:0] rem8;
	logic [6:0] rem;

	always_comb begin
		if (shown_limit >= 8'd200) begin
			hund = 2'd2;
			rem8 = shown_limit - 8'd200;
		end else if (shown_limit >= 8'd100) begin
			hund = 2'd1;
			rem8 = shown_limit - 8'd100;
		end else begin
			hund = 2'd0;
			rem8 = shown_limit;
		end
		rem = rem8[6:0];
	end

	always_comb begin
		case (digit_select)
			POS_TEMP_TENS:  segment_code = seg_digit(tens_of(temperature));
			POS_TEMP_UNITS: segment_code = seg_digit(units_of(temperature));
			POS_MODE_CHAR:  segment_code = high_selected ? SEG_H : SEG_L;
			POS_LIM_HUND:   segment_code = seg_digit({2'd0, hund});
			POS_LIM_TENS:   segment_code = seg_digit(tens_of(rem));
			POS_LIM_UNITS:  segment_code = seg_digit(units_of(rem));
			default:        segment_code = SEG_BLANK;
		endcase
	end

endmodule

FILE: hdl/tac_core.sv
// Controller state registers and the per-event update logic.
module tac_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  tac_pkg::op_t  op,
	input  logic [7:0]    rx_byte,
	output tac_pkg::res_t nxt
);
	import tac_pkg::*;

	logic [7:0] prev_q, prev_d;
	logic [6:0] temp_q, temp_d;
	logic [7:0] upper_q, upper_d;
	logic [7:0] lower_q, lower_d;
	logic       upper_sel_q, upper_sel_d;
	logic       armed_q, armed_d;
	logic       buzzer_q, buzzer_d;
	logic [2:0] digit_q, digit_d;
	logic       flash;
	logic       alarm_pre;

	assign alarm_pre = armed_q &&
		(({1'b0, temp_q} >= upper_q) || ({1'b0, temp_q} <= lower_q));

	always_comb begin
		prev_d      = prev_q;
		temp_d      = temp_q;
		upper_d     = upper_q;
		lower_d     = lower_q;
		upper_sel_d = upper_sel_q;
		armed_d     = armed_q;
		buzzer_d    = buzzer_q;
		digit_d     = digit_q;
		flash       = 1'b0;
		case (op)
			OP_BYTE: begin
				if (prev_q == MARKER_BYTE && rx_byte < TEMP_MAX_EX) begin
					temp_d = rx_byte[6:0];
				end
				prev_d = rx_byte;
			end
			OP_RAISE: begin
				if (upper_sel_q) begin
					if (upper_q != 8'hff) upper_d = upper_q + 8'd1;
				end else begin
					if (lower_q != 8'hff) lower_d = lower_q + 8'd1;
				end
			end
			OP_LOWER: begin
				if (upper_sel_q) begin
					if (upper_q != 8'h00) upper_d = upper_q - 8'd1;
				end else begin
					if (lower_q != 8'h00) lower_d = lower_q - 8'd1;
				end
			end
			OP_MODE: begin
				if (alarm_pre) armed_d = 1'b0;
				else upper_sel_d = ~upper_sel_q;
			end
			OP_BUZZ: begin
				if (alarm_pre) buzzer_d = ~buzzer_q;
			end
			OP_DISPLAY: begin
				digit_d = digit_q + 3'd1;
				flash   = alarm_pre;
			end
			default: begin
			end
		endcase
		// The alarm re-arms once the temperature sits strictly inside the window.
		if ({1'b0, temp_d} < upper_d && {1'b0, temp_d} > lower_d) armed_d = 1'b1;
	end

	always_comb begin
		nxt.temperature   = temp_d;
		nxt.shown_limit   = upper_sel_d ? upper_d : lower_d;
		nxt.high_selected = upper_sel_d;
		nxt.alarm_active  = armed_d &&
			(({1'b0, temp_d} >= upper_d) || ({1'b0, temp_d} <= lower_d));
		nxt.buzzer_level  = buzzer_d;
		nxt.digit_select  = digit_d;
		nxt.led_flash     = flash;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= RST_PREV_BYTE;
			temp_q      <= RST_TEMP;
			upper_q     <= RST_UPPER;
			lower_q     <= RST_LOWER;
			upper_sel_q <= RST_UPPER_SEL;
			armed_q     <= RST_ARMED;
			buzzer_q    <= RST_BUZZER;
			digit_q     <= RST_DIGIT;
		end else if (fire) begin
			prev_q      <= prev_d;
			temp_q      <= temp_d;
			upper_q     <= upper_d;
			lower_q     <= lower_d;
			upper_sel_q <= upper_sel_d;
			armed_q     <= armed_d;
			buzzer_q    <= buzzer_d;
			digit_q     <= digit_d;
		end
	end

endmodule
